// ===== src/fpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpwd_pkg
// Shared types and constants of the flight phase window detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fpwd_pkg;

    // Width of one acceleration sample, tenths of m/s^2
    localparam int SAMPLE_W = 16;
    // Width of the step threshold register
    localparam int THRESH_W = 15;
    // Resting level (9.8 m/s^2) that the history holds after reset
    localparam int REST_LEVEL = 98;
    // Threshold after reset
    localparam int THRESH_RESET = 50;

    // Configuration register indexes
    localparam int REG_STEP_THRESHOLD = 0;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // Flight phase, also the state of the back end
    typedef enum logic [1:0] {
        PH_PRE  = 2'd0,
        PH_LIFT = 2'd1,
        PH_MECO = 2'd2
    } phase_t;

    // Event reported with each result
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_LIFT = 2'd1,
        EV_MECO = 2'd2
    } event_t;

    // Classification of one sample by the front end
    typedef struct packed {
        logic rise;   // newer sum - older sum >= limit
        logic fall;   // older sum - newer sum >= limit
    } cls_t;

endpackage

`default_nettype wire

// ===== src/flight_phase_window_detector.sv =====
// ----------------------------------------------------------------------------
// flight_phase_window_detector
// Dual moving-average step detector for liftoff and MECO.
// ----------------------------------------------------------------------------
// Takes one signed acceleration sample (tenths of m/s^2) per transaction and
// returns one result per sample: the current phase and the event it caused.
// The newer window sums the last WINDOW samples, the older window the WINDOW
// samples ending at the newer window's oldest one. After reset the history
// holds 9.8 m/s^2 everywhere. Sustained rate is one sample per clock while
// m_tready stays high; otherwise back-pressure stalls the input. The edge
// that accepts a sample loads the window sum registers, the classification
// then moves into the queue, and then the output register is loaded and raises
// m_tvalid. The sums update by one add and one subtract per window on a shift
// line of 2*WINDOW-1 samples. step_threshold sits at byte address 0; write it
// only while no sample is in flight.
`default_nettype none

module flight_phase_window_detector
    import fpwd_pkg::*;
#(
    parameter int WINDOW = 30
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Sample stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] sample
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata      // [1:0] phase, [3:2] event_res, [7:4] zero
);

    logic [THRESH_W-1:0] thresh_reg;
    logic                reg_hit;
    logic                cfg_wr;
    logic                q_in_valid, q_in_ready;
    cls_t                q_in_cls;
    logic                q_out_valid, q_out_ready;
    cls_t                q_out_cls;
    phase_t              phase;
    event_t              event_res;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(REG_STEP_THRESHOLD));
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? {{(32-THRESH_W){1'b0}}, thresh_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_W'(THRESH_RESET);
        end else if (cfg_wr) begin
            thresh_reg <= pwdata[THRESH_W-1:0];
        end
    end

    fpwd_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_sample  (s_tdata),
        .thresh    (thresh_reg),
        .cls_valid (q_in_valid),
        .cls_ready (q_in_ready),
        .cls       (q_in_cls)
    );

    fpwd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_cls    (q_in_cls),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_cls   (q_out_cls)
    );

    fpwd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_valid (q_out_valid),
        .cls_ready (q_out_ready),
        .cls       (q_out_cls),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_phase   (phase),
        .m_event   (event_res)
    );

    assign m_tdata = {4'b0000, 2'(event_res), 2'(phase)};

endmodule

`default_nettype wire

// ===== src/fpwd_front.sv =====
// ----------------------------------------------------------------------------
// fpwd_front
// Sample history, incremental window sums and step classification.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwd_front
    import fpwd_pkg::*;
#(
    parameter int WINDOW = 30
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [SAMPLE_W-1:0] s_sample,
    input  wire logic [THRESH_W-1:0] thresh,
    output logic                     cls_valid,
    input  wire logic                cls_ready,
    output cls_t                     cls
);

    localparam int HIST_D = 2 * WINDOW - 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int LIM_W  = THRESH_W + $clog2(WINDOW);
    localparam int CMP_W  = SUM_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW * REST_LEVEL);
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(WINDOW * THRESH_RESET);

    logic signed [SAMPLE_W-1:0] hist_reg [HIST_D];
    logic signed [SUM_W-1:0]    newer_reg, newer_next;
    logic signed [SUM_W-1:0]    older_reg, older_next;
    logic [LIM_W-1:0]           limit_reg, limit_next;
    logic                       sums_vld_reg, sums_vld_next;
    logic                       accept;
    logic                       push;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [CMP_W-1:0]    diff;
    logic signed [CMP_W-1:0]    lim_s;

    assign sample   = $signed(s_sample);
    assign push     = sums_vld_reg && cls_ready;
    assign s_tready = !sums_vld_reg || cls_ready;
    assign accept   = s_tvalid && s_tready;

    // Newer window drops the sample leaving age WINDOW-1; older window gains
    // the sample of age WINDOW-2 and drops the oldest one of the history.
    assign newer_next = newer_reg + SUM_W'(sample) - SUM_W'(hist_reg[WINDOW-1]);
    assign older_next = older_reg + SUM_W'(hist_reg[WINDOW-2])
                        - SUM_W'(hist_reg[HIST_D-1]);
    assign limit_next = LIM_W'(thresh) * LIM_W'(WINDOW);

    always_comb begin
        sums_vld_next = sums_vld_reg;
        if (accept) begin
            sums_vld_next = 1'b1;
        end else if (push) begin
            sums_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_D; i++) begin
                hist_reg[i] <= SAMPLE_W'(REST_LEVEL);
            end
            newer_reg    <= SUM_RESET;
            older_reg    <= SUM_RESET;
            limit_reg    <= LIM_RESET;
            sums_vld_reg <= 1'b0;
        end else begin
            limit_reg    <= limit_next;
            sums_vld_reg <= sums_vld_next;
            if (accept) begin
                hist_reg[0] <= sample;
                for (int i = 1; i < HIST_D; i++) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                newer_reg <= newer_next;
                older_reg <= older_next;
            end
        end
    end

    // Classify the held sums against the limit
    assign diff      = CMP_W'(newer_reg) - CMP_W'(older_reg);
    assign lim_s     = $signed({{(CMP_W-LIM_W){1'b0}}, limit_reg});
    assign cls.rise  = (diff >= lim_s);
    assign cls.fall  = (-diff >= lim_s);
    assign cls_valid = sums_vld_reg;

`ifndef NO_ASSERTIONS
    // Held sums wait until the queue takes them
    assert property (@(posedge aclk) disable iff (!aresetn)
        sums_vld_reg && !cls_ready && !s_tready |=> sums_vld_reg && $stable(newer_reg))
        else $error("front sums lost while queue was full");
`endif

endmodule

`default_nettype wire

// ===== src/fpwd_queue.sv =====
// ----------------------------------------------------------------------------
// fpwd_queue
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwd_queue
    import fpwd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cls_t in_cls,
    output logic      out_valid,
    input  wire logic out_ready,
    output cls_t      out_cls
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cls_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != CNT_W'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cls   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cls;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// ===== src/fpwd_back.sv =====
// ----------------------------------------------------------------------------
// fpwd_back
// Phase state machine and result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpwd_back
    import fpwd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cls_valid,
    output logic      cls_ready,
    input  wire cls_t cls,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output phase_t    m_phase,
    output event_t    m_event
);

    phase_t state_reg, state_next;
    event_t ev_c;
    phase_t phase_out_reg;
    event_t event_out_reg;
    logic   out_vld_reg, out_vld_next;
    logic   pop;

    assign cls_ready = !out_vld_reg || m_tready;
    assign pop       = cls_valid && cls_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        if (pop) begin
            if (cls.rise && state_reg != PH_LIFT) begin
                state_next = PH_LIFT;
            end else if (cls.fall && state_reg != PH_MECO) begin
                state_next = PH_MECO;
            end
        end
    end

    // Event of the popped sample
    always_comb begin
        ev_c = EV_NONE;
        if (cls.rise && state_reg != PH_LIFT) begin
            ev_c = EV_LIFT;
        end else if (cls.fall && state_reg != PH_MECO) begin
            ev_c = EV_MECO;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (pop) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PH_PRE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            phase_out_reg <= state_next;
            event_out_reg <= ev_c;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_phase  = phase_out_reg;
    assign m_event  = event_out_reg;

`ifndef NO_ASSERTIONS
    // A reported event names the phase that was entered
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && event_out_reg != EV_NONE |->
            logic'(event_out_reg) == logic'(phase_out_reg)
            && 2'(event_out_reg) == 2'(phase_out_reg))
        else $error("event does not match phase");

    // Phase moves only when a sample is consumed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> state_reg == $past(state_reg))
        else $error("phase changed without a sample");
`endif

endmodule

`default_nettype wire
